FILE: rtl/core/gbpl_pkg.sv
// Shared types and constants of the grid path length unit.
package gbpl_pkg;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic REG_ROWS_IN_USE = 1'b0;
    localparam logic REG_COLS_IN_USE = 1'b1;

    localparam int CFG_W   = 5;
    localparam int COORD_W = 4;
    localparam int DIST_W  = 8;
    // wide enough for any coordinate, register value or grid bound
    localparam int CMP_W   = 9;

    localparam logic [CFG_W-1:0]  ROWS_RESET = 5'd15;
    localparam logic [CFG_W-1:0]  COLS_RESET = 5'd14;
    localparam logic [DIST_W-1:0] DIST_MAX   = 8'hFF;

    typedef logic [1:0] dir_t;
    localparam dir_t DIR_N = 2'd0;
    localparam dir_t DIR_E = 2'd1;
    localparam dir_t DIR_S = 2'd2;
    localparam dir_t DIR_W = 2'd3;

    typedef struct packed {
        logic write_cell;
        logic latch_query;
        logic clear_step;
        logic read_start;
        logic read_end;
        logic seed;
        logic pop;
        logic load_cell;
        logic issue;
        logic eval;
        logic finish;
    } dp_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic in_range;
        logic ends_blocked;
        logic same_cell;
        logic queue_empty;
        logic last_nbr;
        logic hit;
    } dp_status_t;

endpackage

FILE: rtl/core/gbpl_ram.sv
// Generic single-write, single-read RAM with registered read data.
module gbpl_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/core/gbpl_datapath.sv
// Datapath: grid map, visited marks, search queue, neighbor walk and result registers.
module gbpl_datapath #(
    parameter int MAX_ROWS = 16,
    parameter int MAX_COLS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  gbpl_pkg::dp_cmd_t             cmd,
    output gbpl_pkg::dp_status_t          status,
    input  logic                          cfg_we,
    input  logic                          cfg_index,
    input  logic [gbpl_pkg::CFG_W-1:0]    cfg_data,
    input  logic [gbpl_pkg::COORD_W-1:0]  cell_row,
    input  logic [gbpl_pkg::COORD_W-1:0]  cell_col,
    input  logic                          cell_blocked,
    input  logic [gbpl_pkg::COORD_W-1:0]  start_row,
    input  logic [gbpl_pkg::COORD_W-1:0]  start_col,
    input  logic [gbpl_pkg::COORD_W-1:0]  end_row,
    input  logic [gbpl_pkg::COORD_W-1:0]  end_col,
    output logic                          reachable,
    output logic [gbpl_pkg::DIST_W-1:0]   distance
);

    import gbpl_pkg::*;

    localparam int CELLS = MAX_ROWS * MAX_COLS;
    localparam int AW    = $clog2(CELLS);
    localparam int RW    = $clog2(MAX_ROWS);
    localparam int CW    = $clog2(MAX_COLS);
    localparam int QW    = DIST_W + RW + CW;

    function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] r,
                                                 input logic [CW-1:0] c);
        return AW'(r * MAX_COLS + c);
    endfunction

    // configuration
    logic [CFG_W-1:0] rows_reg, rows_next;
    logic [CFG_W-1:0] cols_reg, cols_next;
    logic [CMP_W-1:0] lim_r, lim_c;

    // query endpoints
    logic [COORD_W-1:0] sr_reg, sr_next, sc_reg, sc_next;
    logic [COORD_W-1:0] er_reg, er_next, ec_reg, ec_next;
    logic [RW-1:0]      s_row, e_row;
    logic [CW-1:0]      s_col, e_col;
    logic [AW-1:0]      s_addr, e_addr;

    // search control
    logic [AW-1:0]      clr_cnt_reg, clr_cnt_next;
    logic [AW:0]        head_reg, head_next;
    logic [AW:0]        tail_reg, tail_next;
    dir_t               k_reg, k_next;
    logic               pend_valid_reg, pend_valid_next;
    logic               found_reg, found_next;
    logic               bs_reg, bs_next;

    // current cell and pending neighbor
    logic [RW-1:0]      p_row_reg, p_row_next, pend_row_reg, pend_row_next;
    logic [CW-1:0]      p_col_reg, p_col_next, pend_col_reg, pend_col_next;
    logic [DIST_W-1:0]  p_dist_reg, p_dist_next, dist_reg, dist_next;
    logic [DIST_W-1:0]  nxt_dist;

    logic               reachable_reg, reachable_next;
    logic [DIST_W-1:0]  distance_reg, distance_next;

    // neighbor
    logic               nbr_ok;
    logic [RW-1:0]      nbr_row;
    logic [CW-1:0]      nbr_col;
    logic [AW-1:0]      nbr_addr, pend_addr;

    // memories
    logic               blk_we, blk_wdata, blk_rdata;
    logic [AW-1:0]      blk_waddr, blk_raddr;
    logic               vis_we, vis_wdata, vis_rdata;
    logic [AW-1:0]      vis_waddr;
    logic               q_we;
    logic [AW-1:0]      q_waddr;
    logic [QW-1:0]      q_wdata, q_rdata;

    logic               load_ok, seed_ok, push, hit, in_range, ends_blocked, same_cell;

    assign lim_r = (CMP_W'(rows_reg) > CMP_W'(MAX_ROWS)) ? CMP_W'(MAX_ROWS) : CMP_W'(rows_reg);
    assign lim_c = (CMP_W'(cols_reg) > CMP_W'(MAX_COLS)) ? CMP_W'(MAX_COLS) : CMP_W'(cols_reg);

    assign s_row  = RW'(sr_reg);
    assign s_col  = CW'(sc_reg);
    assign e_row  = RW'(er_reg);
    assign e_col  = CW'(ec_reg);
    assign s_addr = cell_addr(s_row, s_col);
    assign e_addr = cell_addr(e_row, e_col);

    assign in_range = (CMP_W'(sr_reg) < lim_r) && (CMP_W'(sc_reg) < lim_c) &&
                      (CMP_W'(er_reg) < lim_r) && (CMP_W'(ec_reg) < lim_c);
    assign same_cell    = (sr_reg == er_reg) && (sc_reg == ec_reg);
    assign ends_blocked = bs_reg | blk_rdata;

    assign load_ok = (CMP_W'(cell_row) < CMP_W'(MAX_ROWS)) &&
                     (CMP_W'(cell_col) < CMP_W'(MAX_COLS));

    always_comb
    begin
        nbr_ok  = 1'b0;
        nbr_row = p_row_reg;
        nbr_col = p_col_reg;
        case (k_reg)
            DIR_N:
            begin
                nbr_ok  = (p_row_reg != '0);
                nbr_row = p_row_reg - RW'(1);
            end
            DIR_E:
            begin
                nbr_ok  = (CMP_W'(p_col_reg) + CMP_W'(1)) < lim_c;
                nbr_col = p_col_reg + CW'(1);
            end
            DIR_S:
            begin
                nbr_ok  = (CMP_W'(p_row_reg) + CMP_W'(1)) < lim_r;
                nbr_row = p_row_reg + RW'(1);
            end
            DIR_W:
            begin
                nbr_ok  = (p_col_reg != '0);
                nbr_col = p_col_reg - CW'(1);
            end
            default:
            begin
                nbr_ok = 1'b0;
            end
        endcase
    end

    assign nbr_addr  = cell_addr(nbr_row, nbr_col);
    assign pend_addr = cell_addr(pend_row_reg, pend_col_reg);

    assign nxt_dist = (p_dist_reg == DIST_MAX) ? DIST_MAX : p_dist_reg + DIST_W'(1);
    assign seed_ok  = cmd.seed & ~ends_blocked;
    assign push     = cmd.eval & pend_valid_reg & ~blk_rdata & ~vis_rdata;
    assign hit      = push & (pend_row_reg == e_row) & (pend_col_reg == e_col);

    // blocked map: written by loads, read for endpoints and neighbors
    assign blk_we    = cmd.write_cell & load_ok;
    assign blk_waddr = cell_addr(RW'(cell_row), CW'(cell_col));
    assign blk_wdata = cell_blocked;
    assign blk_raddr = cmd.read_start ? s_addr : (cmd.read_end ? e_addr : nbr_addr);

    // visited marks: swept clear at query start, set on seed and push
    assign vis_we    = cmd.clear_step | seed_ok | push;
    assign vis_waddr = cmd.clear_step ? clr_cnt_reg : (cmd.seed ? s_addr : pend_addr);
    assign vis_wdata = ~cmd.clear_step;

    // queue entries carry the step count along with the cell
    assign q_we    = seed_ok | push;
    assign q_waddr = cmd.seed ? '0 : tail_reg[AW-1:0];
    assign q_wdata = cmd.seed ? {DIST_W'(0), s_row, s_col}
                              : {nxt_dist, pend_row_reg, pend_col_reg};

    gbpl_ram #(.WIDTH(1), .DEPTH(CELLS)) u_blk_ram (
        .clk   (clk),
        .we    (blk_we),
        .waddr (blk_waddr),
        .wdata (blk_wdata),
        .raddr (blk_raddr),
        .rdata (blk_rdata)
    );

    gbpl_ram #(.WIDTH(1), .DEPTH(CELLS)) u_vis_ram (
        .clk   (clk),
        .we    (vis_we),
        .waddr (vis_waddr),
        .wdata (vis_wdata),
        .raddr (nbr_addr),
        .rdata (vis_rdata)
    );

    gbpl_ram #(.WIDTH(QW), .DEPTH(CELLS)) u_queue_ram (
        .clk   (clk),
        .we    (q_we),
        .waddr (q_waddr),
        .wdata (q_wdata),
        .raddr (head_reg[AW-1:0]),
        .rdata (q_rdata)
    );

    always_comb
    begin
        rows_next       = rows_reg;
        cols_next       = cols_reg;
        sr_next         = sr_reg;
        sc_next         = sc_reg;
        er_next         = er_reg;
        ec_next         = ec_reg;
        clr_cnt_next    = clr_cnt_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        k_next          = k_reg;
        pend_valid_next = pend_valid_reg;
        found_next      = found_reg;
        bs_next         = bs_reg;
        p_row_next      = p_row_reg;
        p_col_next      = p_col_reg;
        p_dist_next     = p_dist_reg;
        pend_row_next   = pend_row_reg;
        pend_col_next   = pend_col_reg;
        dist_next       = dist_reg;
        reachable_next  = reachable_reg;
        distance_next   = distance_reg;

        if (cfg_we)
        begin
            case (cfg_index)
                REG_ROWS_IN_USE: rows_next = cfg_data;
                REG_COLS_IN_USE: cols_next = cfg_data;
                default:         rows_next = rows_reg;
            endcase
        end

        if (cmd.latch_query)
        begin
            sr_next      = start_row;
            sc_next      = start_col;
            er_next      = end_row;
            ec_next      = end_col;
            clr_cnt_next = '0;
            head_next    = '0;
            tail_next    = '0;
            found_next   = 1'b0;
        end

        if (cmd.clear_step)
        begin
            clr_cnt_next = clr_cnt_reg + AW'(1);
        end

        if (cmd.read_end)
        begin
            bs_next = blk_rdata;
        end

        if (seed_ok)
        begin
            tail_next = (AW + 1)'(1);
            if (same_cell)
            begin
                found_next = 1'b1;
                dist_next  = '0;
            end
        end

        if (cmd.pop)
        begin
            head_next = head_reg + (AW + 1)'(1);
        end

        if (cmd.load_cell)
        begin
            {p_dist_next, p_row_next, p_col_next} = q_rdata;
            k_next          = DIR_N;
            pend_valid_next = 1'b0;
        end

        if (cmd.issue)
        begin
            k_next          = k_reg + 2'd1;
            pend_valid_next = nbr_ok;
            pend_row_next   = nbr_row;
            pend_col_next   = nbr_col;
        end
        else if (cmd.eval)
        begin
            pend_valid_next = 1'b0;
        end

        if (push)
        begin
            tail_next = tail_reg + (AW + 1)'(1);
        end

        if (hit)
        begin
            found_next = 1'b1;
            dist_next  = nxt_dist;
        end

        if (cmd.finish)
        begin
            reachable_next = found_reg;
            distance_next  = found_reg ? dist_reg : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg       <= ROWS_RESET;
            cols_reg       <= COLS_RESET;
            clr_cnt_reg    <= '0;
            head_reg       <= '0;
            tail_reg       <= '0;
            k_reg          <= DIR_N;
            pend_valid_reg <= 1'b0;
            found_reg      <= 1'b0;
            reachable_reg  <= 1'b0;
            distance_reg   <= '0;
        end
        else
        begin
            rows_reg       <= rows_next;
            cols_reg       <= cols_next;
            clr_cnt_reg    <= clr_cnt_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            k_reg          <= k_next;
            pend_valid_reg <= pend_valid_next;
            found_reg      <= found_next;
            reachable_reg  <= reachable_next;
            distance_reg   <= distance_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sr_reg       <= sr_next;
        sc_reg       <= sc_next;
        er_reg       <= er_next;
        ec_reg       <= ec_next;
        bs_reg       <= bs_next;
        p_row_reg    <= p_row_next;
        p_col_reg    <= p_col_next;
        p_dist_reg   <= p_dist_next;
        pend_row_reg <= pend_row_next;
        pend_col_reg <= pend_col_next;
        dist_reg     <= dist_next;
    end

    assign status.clear_last   = (clr_cnt_reg == AW'(CELLS - 1));
    assign status.in_range     = in_range;
    assign status.ends_blocked = ends_blocked;
    assign status.same_cell    = same_cell;
    assign status.queue_empty  = (head_reg == tail_reg);
    assign status.last_nbr     = (k_reg == DIR_W);
    assign status.hit          = hit;

    assign reachable = reachable_reg;
    assign distance  = distance_reg;

endmodule

FILE: rtl/core/gbpl_ctrl.sv
// Controller: sequences loads, the clear sweep and the breadth-first walk.
module gbpl_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic                 operation,
    input  gbpl_pkg::dp_status_t status,
    output gbpl_pkg::dp_cmd_t    cmd,
    output logic                 busy,
    output logic                 done
);

    import gbpl_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLEAR,
        S_RD_START,
        S_RD_END,
        S_SEED,
        S_POP,
        S_LOAD,
        S_NBR,
        S_FLUSH,
        S_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   busy_reg, busy_next;
    logic   done_reg, done_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (operation == OP_LOAD)
                    begin
                        cmd.write_cell = 1'b1;
                    end
                    else
                    begin
                        cmd.latch_query = 1'b1;
                        state_next      = S_CLEAR;
                    end
                end
            end
            S_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (status.clear_last)
                begin
                    state_next = status.in_range ? S_RD_START : S_DONE;
                end
            end
            S_RD_START:
            begin
                cmd.read_start = 1'b1;
                state_next     = S_RD_END;
            end
            S_RD_END:
            begin
                cmd.read_end = 1'b1;
                state_next   = S_SEED;
            end
            S_SEED:
            begin
                cmd.seed   = 1'b1;
                state_next = (status.ends_blocked || status.same_cell) ? S_DONE : S_POP;
            end
            S_POP:
            begin
                if (status.queue_empty)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.pop    = 1'b1;
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                cmd.load_cell = 1'b1;
                state_next    = S_NBR;
            end
            S_NBR:
            begin
                cmd.issue = 1'b1;
                cmd.eval  = 1'b1;
                if (status.hit)
                begin
                    state_next = S_DONE;
                end
                else if (status.last_nbr)
                begin
                    state_next = S_FLUSH;
                end
            end
            S_FLUSH:
            begin
                cmd.eval   = 1'b1;
                state_next = status.hit ? S_DONE : S_POP;
            end
            S_DONE:
            begin
                cmd.finish = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy_next = (state_next != S_IDLE);
    assign done_next = (state_reg == S_DONE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= busy_next;
            done_reg  <= done_next;
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;

endmodule

FILE: rtl/core/grid_bfs_path_length_unit.sv
// Top level: grid shortest path length by four-neighbor breadth-first search.
// Load (operation 0): busy stays low, and the next transfer may follow at once.
// Query: visited-mark clearing over all MAX_ROWS*MAX_COLS cells, endpoint checks, then for
//   each expanded cell a queue read, four neighbor probes and one flush, then done.
//   One query at a time, no result stall.
// rst_n is asynchronous: state machine idle, queue pointers cleared, rows 15, cols 14.
module grid_bfs_path_length_unit #(
    parameter int MAX_ROWS = 16,
    parameter int MAX_COLS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // command transfer: taken when start is high and busy is low
    input  logic                          start,
    output logic                          busy,
    input  logic                          operation,
    input  logic [gbpl_pkg::COORD_W-1:0]  cell_row,
    input  logic [gbpl_pkg::COORD_W-1:0]  cell_col,
    input  logic                          cell_blocked,
    input  logic [gbpl_pkg::COORD_W-1:0]  start_row,
    input  logic [gbpl_pkg::COORD_W-1:0]  start_col,
    input  logic [gbpl_pkg::COORD_W-1:0]  end_row,
    input  logic [gbpl_pkg::COORD_W-1:0]  end_col,
    // result transfer: one cycle, marked by done
    output logic                          done,
    output logic                          reachable,
    output logic [gbpl_pkg::DIST_W-1:0]   distance,
    // register writes: index 0 rows_in_use, index 1 cols_in_use
    input  logic                          cfg_we,
    input  logic                          cfg_index,
    input  logic [gbpl_pkg::CFG_W-1:0]    cfg_data
);

    import gbpl_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    // Controller accepts only in idle; it walks the clear sweep, checks the
    // endpoints (stopping if out of range, blocked or equal), then pops cells
    // and probes their neighbors until the end cell is marked or the queue runs dry.
    gbpl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .operation (operation),
        .status    (status),
        .cmd       (cmd),
        .busy      (busy),
        .done      (done)
    );

    // Datapath holds the map, visited marks and queue RAMs. Queue entries
    // carry their step count, so no per-cell distance store is needed.
    gbpl_datapath #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cell_row     (cell_row),
        .cell_col     (cell_col),
        .cell_blocked (cell_blocked),
        .start_row    (start_row),
        .start_col    (start_col),
        .end_row      (end_row),
        .end_col      (end_col),
        .reachable    (reachable),
        .distance     (distance)
    );

endmodule

FILE: rtl/core/gbpl_checker.sv
// Port-level checks of the grid path length unit, bound to the top level.
module gbpl_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        start,
    input logic                        busy,
    input logic                        operation,
    input logic                        done,
    input logic                        reachable,
    input logic [gbpl_pkg::DIST_W-1:0] distance
);

    import gbpl_pkg::*;

    // a result only follows a busy cycle and leaves the unit idle
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (!busy && $past(busy)))
        else $error("done without a preceding query");

    // an unreachable answer always reports zero steps
    a_unreach_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !reachable) |-> (distance == '0))
        else $error("nonzero distance on unreachable result");

    // a load transfer leaves busy low and yields no result
    a_load_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && operation == OP_LOAD) |=> (!busy && !done))
        else $error("load raised busy or done");

    // a query transfer makes the unit busy
    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && operation == OP_QUERY) |=> busy)
        else $error("query did not raise busy");

endmodule

bind grid_bfs_path_length_unit gbpl_checker u_gbpl_checker (.*);
